@@ hdl/ats_pkg.sv @@
// Shared types and constants for the audio timestamp synchroniser.
// Used by the interfaces, the controller, the datapath, the divider and the top level.
// Has no dependencies of its own.
package ats_pkg;

  localparam int unsigned TimeW      = 48;
  localparam int unsigned CountW     = 23;
  localparam int unsigned TicksW     = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  // Output runs more than 15 ms ahead of the input.
  localparam logic signed [TimeW-1:0] AheadLimit = TimeW'(90 * 15);
  // Smallest gap that is treated as a discontinuity (70 ms).
  localparam logic signed [TimeW-1:0] GapMin     = TimeW'(90 * 70);
  // Largest gap that is still bridged (one minute).
  localparam logic signed [TimeW-1:0] GapMax     = TimeW'(90000 * 60);

  localparam logic [TicksW-1:0] SilenceTicksReset = TicksW'(2880);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgGapMode      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSilenceTicks = CfgIdxW'(1);

  typedef enum logic [2:0] {
    ACT_RETIMED   = 3'd0,
    ACT_DROP_BACK = 3'd1,
    ACT_DROP_HUGE = 3'd2,
    ACT_SILENCE   = 3'd3,
    ACT_SKIP      = 3'd4,
    ACT_EOS       = 3'd5
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture the input transfer
    logic    resync;     // expected input time := slip-corrected start
    logic    take_gap;   // register the gap against the expected time
    logic    retime;     // place the frame on the contiguous output clock
    logic    skip;       // add the gap to the slip
    logic    div_start;  // start the silence frame count
    logic    fill;       // commit the silence frame advance
    logic    res_clear;  // result without times
    logic    out_load;   // move the result into the output register
    action_e action;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic backward;
    logic ahead;
    logic gap_ge_min;
    logic gap_gt_max;
    logic gap_mode;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/ats_if.sv @@
// Stream interfaces for the audio timestamp synchroniser: frame times in, results out.
// Depends on ats_pkg for the field widths.
interface ats_in_if;
  import ats_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TimeW-1:0]  frame_start;
  logic signed [TimeW-1:0]  frame_stop;
  logic                     end_of_stream;

  modport source (output valid, frame_start, frame_stop, end_of_stream, input ready);
  modport sink   (input valid, frame_start, frame_stop, end_of_stream, output ready);
endinterface

interface ats_out_if;
  import ats_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               action;
  logic signed [TimeW-1:0]  out_start;
  logic signed [TimeW-1:0]  out_stop;
  logic [CountW-1:0]        silence_count;
  logic signed [TimeW-1:0]  silence_start;
  logic [CountW-1:0]        slip_added;

  modport source (output valid, action, out_start, out_stop, silence_count, silence_start,
                  slip_added, input ready);
  modport sink   (input valid, action, out_start, out_stop, silence_count, silence_start,
                  slip_added, output ready);
endinterface

@@ hdl/ats_div.sv @@
// Restoring divider, one quotient bit per cycle, for the silence frame count.
// Depends on ats_pkg for the count and tick widths.
module ats_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ats_pkg::CountW-1:0]  num_i,
  input  logic [ats_pkg::TicksW-1:0]  den_i,
  output logic                        done_o,
  output logic [ats_pkg::CountW-1:0]  quo_o,
  output logic [ats_pkg::TicksW-1:0]  rem_o
);
  import ats_pkg::*;

  localparam int unsigned CntW = $clog2(CountW);
  localparam logic [CntW-1:0] LastStep = CntW'(CountW - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CountW-1:0]   quo_q, quo_d;
  logic [TicksW-1:0]   rem_q, rem_d;
  logic [TicksW-1:0]   den_q, den_d;
  logic [CountW-1:0]   num_q, num_d;
  logic [TicksW:0]     rem_sh;
  logic                fits;

  assign rem_sh = {rem_q, quo_q[CountW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      num_d  = num_i;
    end else if (busy_q) begin
      quo_d = {quo_q[CountW-2:0], fits};
      if (fits) begin
        rem_d = TicksW'(rem_sh - {1'b0, den_q});
      end else begin
        rem_d = rem_sh[TicksW-1:0];
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_div_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (40'(quo_q) * 40'(den_q) + 40'(rem_q)) == 40'(num_q))
    else $error("divider result does not reproduce the numerator");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");

endmodule

@@ hdl/ats_datapath.sv @@
// Datapath of the audio timestamp synchroniser: time state, configuration, result staging,
// the silence count divider and the output register. Depends on ats_pkg, ats_if and ats_div.
module ats_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [ats_pkg::TimeW-1:0] in_start_i,
  input  logic signed [ats_pkg::TimeW-1:0] in_stop_i,
  input  logic                          cfg_we_i,
  input  logic [ats_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ats_pkg::CfgDataW-1:0]  cfg_data_i,
  input  ats_pkg::cmd_t                 cmd_i,
  output ats_pkg::sts_t                 sts_o,
  ats_out_if.source                     out_o
);
  import ats_pkg::*;

  // Configuration.
  logic              gap_mode_q;
  logic [TicksW-1:0] ticks_q;

  // Time state.
  logic [TimeW-1:0]  exp_q;
  logic [TimeW-1:0]  next_q;
  logic [TimeW-1:0]  slip_q;

  // Item working registers.
  logic [TimeW-1:0]  in_start_q, in_stop_q;
  logic [TimeW-1:0]  start_q, dur_q, gap_q;

  // Result staging.
  logic [TimeW-1:0]  res_start_q, res_stop_q, res_sstart_q;
  logic [CountW-1:0] res_count_q, res_slip_q;

  // Output register.
  logic              out_valid_q;
  logic [2:0]        out_action_q;
  logic [TimeW-1:0]  out_start_q, out_stop_q, out_sstart_q;
  logic [CountW-1:0] out_count_q, out_slip_q;

  logic [TicksW-1:0] ticks_eff;
  logic [CountW-1:0] div_num;
  logic [CountW-1:0] div_quo;
  logic [TicksW-1:0] div_rem;
  logic              div_done;
  logic [CountW-1:0] adv;
  logic [TimeW-1:0]  back_diff, ahead_diff, next_plus_dur;

  assign ticks_eff     = (ticks_q == '0) ? TicksW'(1) : ticks_q;
  assign div_num       = gap_q[CountW-1:0] + CountW'(ticks_eff[TicksW-1:1]);
  // quotient * divisor is the numerator less the remainder
  assign adv           = div_num - CountW'(div_rem);
  assign back_diff     = start_q - exp_q;
  assign ahead_diff    = next_q - start_q;
  assign next_plus_dur = next_q + dur_q;

  ats_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (ticks_eff),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_comb begin
    sts_o.backward   = back_diff[TimeW-1];
    sts_o.ahead      = $signed(ahead_diff) > AheadLimit;
    sts_o.gap_ge_min = $signed(gap_q) >= GapMin;
    sts_o.gap_gt_max = $signed(gap_q) > GapMax;
    sts_o.gap_mode   = gap_mode_q;
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || out_o.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_mode_q  <= 1'b0;
      ticks_q     <= SilenceTicksReset;
      exp_q       <= '0;
      next_q      <= '0;
      slip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgGapMode:      gap_mode_q <= cfg_data_i[0];
          CfgSilenceTicks: ticks_q    <= cfg_data_i[TicksW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.resync) begin
        exp_q <= start_q;
      end
      if (cmd_i.retime) begin
        exp_q  <= exp_q + dur_q;
        next_q <= next_plus_dur;
      end
      if (cmd_i.skip) begin
        slip_q <= slip_q + gap_q;
      end
      if (cmd_i.fill) begin
        exp_q  <= exp_q + TimeW'(adv);
        next_q <= next_q + TimeW'(adv);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_start_q <= in_start_i;
      in_stop_q  <= in_stop_i;
      start_q    <= in_start_i - slip_q;
      dur_q      <= in_stop_i - in_start_i;
    end
    if (cmd_i.take_gap) begin
      gap_q <= back_diff;
    end
    // The controller never sets two staging commands together, so at most one is set.
    if (cmd_i.retime) begin
      res_start_q  <= next_q;
      res_stop_q   <= next_plus_dur;
      res_sstart_q <= '0;
      res_count_q  <= '0;
      res_slip_q   <= '0;
    end else if (cmd_i.skip) begin
      res_start_q  <= in_start_q;
      res_stop_q   <= in_stop_q;
      res_sstart_q <= '0;
      res_count_q  <= '0;
      res_slip_q   <= gap_q[CountW-1:0];
    end else if (cmd_i.fill) begin
      res_start_q  <= in_start_q;
      res_stop_q   <= in_stop_q;
      res_sstart_q <= next_q;
      res_count_q  <= div_quo;
      res_slip_q   <= '0;
    end else if (cmd_i.res_clear) begin
      res_start_q  <= '0;
      res_stop_q   <= '0;
      res_sstart_q <= '0;
      res_count_q  <= '0;
      res_slip_q   <= '0;
    end
    if (cmd_i.out_load) begin
      out_action_q <= cmd_i.action;
      out_start_q  <= res_start_q;
      out_stop_q   <= res_stop_q;
      out_sstart_q <= res_sstart_q;
      out_count_q  <= res_count_q;
      out_slip_q   <= res_slip_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.action        = out_action_q;
  assign out_o.out_start     = out_start_q;
  assign out_o.out_stop      = out_stop_q;
  assign out_o.silence_count = out_count_q;
  assign out_o.silence_start = out_sstart_q;
  assign out_o.slip_added    = out_slip_q;

endmodule

@@ hdl/ats_ctrl.sv @@
// Controller of the audio timestamp synchroniser: sequences one frame through the datapath.
// Depends on ats_pkg for the command and status structs and the action codes.
module ats_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_eos_i,
  output logic           in_ready_o,
  input  ats_pkg::sts_t  sts_i,
  output ats_pkg::cmd_t  cmd_o
);
  import ats_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_GAP,
    S_CLASSIFY,
    S_DIVIDE,
    S_OUTPUT
  } state_e;

  state_e  state_q;
  action_e action_q;
  logic    drop_q;
  logic    drop_now;

  assign drop_now = sts_i.backward && (drop_q || sts_i.ahead);

  always_comb begin
    cmd_o        = '0;
    cmd_o.action = action_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i;
        cmd_o.res_clear = in_valid_i && in_eos_i;
      end
      S_COMPARE: begin
        cmd_o.res_clear = drop_now;
        cmd_o.resync    = !drop_now && (sts_i.backward || drop_q);
      end
      S_GAP: begin
        cmd_o.take_gap = 1'b1;
      end
      S_CLASSIFY: begin
        priority if (!sts_i.gap_ge_min) begin
          cmd_o.retime = 1'b1;
        end else if (sts_i.gap_gt_max) begin
          cmd_o.res_clear = 1'b1;
        end else if (sts_i.gap_mode) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_DIVIDE: begin
        cmd_o.fill = sts_i.div_done;
      end
      S_OUTPUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      action_q <= ACT_RETIMED;
      drop_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_eos_i) begin
              action_q <= ACT_EOS;
              state_q  <= S_OUTPUT;
            end else begin
              state_q <= S_COMPARE;
            end
          end
        end
        S_COMPARE: begin
          if (drop_now) begin
            drop_q   <= 1'b1;
            action_q <= ACT_DROP_BACK;
            state_q  <= S_OUTPUT;
          end else begin
            drop_q  <= 1'b0;
            state_q <= S_GAP;
          end
        end
        S_GAP: begin
          state_q <= S_CLASSIFY;
        end
        S_CLASSIFY: begin
          priority if (!sts_i.gap_ge_min) begin
            action_q <= ACT_RETIMED;
            state_q  <= S_OUTPUT;
          end else if (sts_i.gap_gt_max) begin
            action_q <= ACT_DROP_HUGE;
            state_q  <= S_OUTPUT;
          end else if (sts_i.gap_mode) begin
            action_q <= ACT_SKIP;
            state_q  <= S_OUTPUT;
          end else begin
            action_q <= ACT_SILENCE;
            state_q  <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (sts_i.div_done) begin
            state_q <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q != S_IDLE)
    else $error("input transfer did not start a frame");

  a_drop_run_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPARE && drop_now) |=> drop_q && action_q == ACT_DROP_BACK)
    else $error("backward frame dropped without a drop run");

endmodule

@@ hdl/audio_timestamp_sync_top.sv @@
// Top level of the audio timestamp synchroniser: controller, datapath and stream ports.
// Depends on ats_pkg, ats_if, ats_div, ats_datapath and ats_ctrl.

// Each input transfer carries one audio frame's 90 kHz start and stop time, or an
// end-of-stream mark, and produces exactly one result transfer. The accumulated
// pass-through slip is first taken off the start time. A frame that runs backwards is
// dropped while a drop run is in progress or when the output clock is more than 15 ms
// ahead; otherwise the expected time is resynchronised to it. A gap beyond one minute
// drops the frame; a gap of 70 ms or more is either added to the slip (gap_mode 1) or
// bridged by a rounded count of silence frames, and the frame then passes unchanged.
// Every other frame is retimed onto the contiguous output clock. One frame is worked on
// at a time by the controller: an end-of-stream mark goes from idle straight to output, a
// backward frame that is dropped goes through compare to output, a retimed, skipped or
// huge-gap frame through compare, gap and classify, and a silence fill also waits in divide
// for the divider, which yields one quotient bit per cycle over the 23-bit count. The result
// sits in an output register, so the next frame is taken while the previous result still
// waits; a result is loaded only once that register is free. Configuration writes take
// effect at once and are meant for idle periods only.
module audio_timestamp_sync_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ats_in_if.sink                         in_i,
  ats_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [ats_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ats_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ats_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The controller only needs the handshake and the end-of-stream flag; the frame times
  // go straight to the datapath.
  ats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_eos_i   (in_i.end_of_stream),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  ats_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_start_i  (in_i.frame_start),
    .in_stop_i   (in_i.frame_stop),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

@@ tb/tb_audio_timestamp_sync_top.sv @@
// Self-checking testbench for audio_timestamp_sync_top: directed rows, then random frame streams.
// Depends on ats_pkg and the ats_in_if / ats_out_if stream interfaces, and on the RTL alone.
// Every result transfer is checked against a cycle-free predictor of the frame retiming.
module tb_audio_timestamp_sync_top;
  import ats_pkg::*;

  // The slowest frame is a silence fill, which waits for the divider, and the output register
  // comes after it. This many quiet cycles after the last result means nothing is still in flight.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseItems   = 150;

  localparam logic [TimeW-1:0] TMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [TimeW-1:0] TMin = 48'h8000_0000_0000;

  typedef logic [TimeW-1:0] tick_t;

  typedef struct packed {
    tick_t start;
    tick_t stop;
    logic  eos;
  } frame_t;

  typedef struct packed {
    action_e           action;
    tick_t             out_start;
    tick_t             out_stop;
    logic [CountW-1:0] silence_count;
    tick_t             silence_start;
    logic [CountW-1:0] slip_added;
  } sync_res_t;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_SET_MODE,
    ROW_SET_TICKS
  } row_kind_e;

  // One directed step. Where typed is set, the result is written out by hand: action, start and
  // stop, with every other field zero. Otherwise the predictor supplies the expected result.
  typedef struct packed {
    row_kind_e           kind;
    tick_t               start;
    tick_t               stop;
    logic                eos;
    logic [CfgDataW-1:0] value;
    logic                typed;
    action_e             want_action;
    tick_t               want_start;
    tick_t               want_stop;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ats_in_if  in_if ();
  ats_out_if out_if ();

  audio_timestamp_sync_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: a copy of the block's registers and of its two time bases.
  logic              mode_q;
  logic [TicksW-1:0] ticks_q;
  tick_t             exp_in_time;
  tick_t             next_out_time;
  tick_t             slip_acc;
  logic              in_drop_run;

  // Results predicted for accepted frames, oldest first.
  sync_res_t due_results [$];
  int unsigned mismatches;

  // Position of the well-formed input stream, in input time (slip included).
  tick_t src_cursor;
  bit    src_pause_on;
  bit    sink_stall_on;

  // The directed part. It opens straight after reset so that a drop run can start while the
  // expected time is still zero, then walks the gap thresholds, the silence frame lengths at
  // both ends (zero too, which counts as one), skip mode and the extremes of the time fields.
  dir_row_t dir_rows [24] = '{
    '{ROW_FRAME, TMax, TMin, 1'b1, 16'd0, 1'b1, ACT_EOS, 48'd0, 48'd0},
    '{ROW_FRAME, -48'sd2000, -48'sd80, 1'b0, 16'd0, 1'b1, ACT_DROP_BACK, 48'd0, 48'd0},
    '{ROW_FRAME, -48'sd1000, 48'd920, 1'b0, 16'd0, 1'b1, ACT_DROP_BACK, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd0, 48'd1920, 1'b0, 16'd0, 1'b1, ACT_RETIMED, 48'd0, 48'd1920},
    '{ROW_FRAME, 48'd1920, 48'd3840, 1'b0, 16'd0, 1'b1, ACT_RETIMED, 48'd1920, 48'd3840},
    '{ROW_FRAME, 48'd3000, 48'd4920, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd0, 48'd1920, 1'b0, 16'd0, 1'b1, ACT_DROP_BACK, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd4920, 48'd6840, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd13140, 48'd15060, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd18899, 48'd20819, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5414520, 48'd5416440, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd10814521, 48'd10816441, 1'b0, 16'd0, 1'b1, ACT_DROP_HUGE, 48'd0, 48'd0},
    '{ROW_SET_TICKS, 48'd0, 48'd0, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5421520, 48'd5423440, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_SET_TICKS, 48'd0, 48'd0, 1'b0, 16'd65535, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5427820, 48'd5429740, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_SET_TICKS, 48'd0, 48'd0, 1'b0, 16'd1, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5428000, 48'd5429000, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_SET_MODE, 48'd0, 48'd0, 1'b0, 16'd1, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5528000, 48'd5529920, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, 48'd5529920, 48'd5531840, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, TMax, TMin, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_FRAME, TMin, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0},
    '{ROW_SET_MODE, 48'd0, 48'd0, 1'b0, 16'd0, 1'b0, ACT_RETIMED, 48'd0, 48'd0}
  };

  // Wrapped 48-bit difference, read as a signed number.
  function automatic logic signed [TimeW-1:0] tick_diff(tick_t a, tick_t b);
    return a - b;
  endfunction

  // Works out the result of one accepted frame and advances the predictor state with it.
  function automatic sync_res_t retime_frame(frame_t f);
    sync_res_t               r;
    tick_t                   start;
    tick_t                   dur;
    logic signed [TimeW-1:0] gap;
    longint unsigned         span;
    longint unsigned         unit_ticks;
    longint unsigned         frames;
    longint unsigned         advance;
    r = '0;
    if (f.eos) begin
      // End of stream leaves the state alone and ignores the times.
      r.action = ACT_EOS;
      return r;
    end
    start = f.start - slip_acc;
    if (tick_diff(start, exp_in_time) < 0) begin
      if (in_drop_run || tick_diff(next_out_time, start) > AheadLimit) begin
        in_drop_run = 1'b1;
        r.action = ACT_DROP_BACK;
        return r;
      end
      exp_in_time = start;
    end
    if (in_drop_run) begin
      in_drop_run = 1'b0;
      exp_in_time = start;
    end
    gap = tick_diff(start, exp_in_time);
    if (gap >= GapMin) begin
      if (gap > GapMax) begin
        r.action = ACT_DROP_HUGE;
        return r;
      end
      r.out_start = f.start;
      r.out_stop  = f.stop;
      if (mode_q) begin
        slip_acc     = slip_acc + tick_t'(gap);
        r.action     = ACT_SKIP;
        r.slip_added = CountW'(gap);
      end else begin
        span       = gap;
        unit_ticks = ticks_q;
        if (unit_ticks == 0) unit_ticks = 1;
        frames  = (span + unit_ticks / 2) / unit_ticks;
        advance = frames * unit_ticks;
        r.action        = ACT_SILENCE;
        r.silence_count = CountW'(frames);
        r.silence_start = next_out_time;
        exp_in_time     = exp_in_time + tick_t'(advance);
        next_out_time   = next_out_time + tick_t'(advance);
      end
      return r;
    end
    dur = f.stop - f.start;
    r.action      = ACT_RETIMED;
    r.out_start   = next_out_time;
    next_out_time = next_out_time + dur;
    r.out_stop    = next_out_time;
    exp_in_time   = exp_in_time + dur;
    return r;
  endfunction

  function automatic tick_t rand_ticks();
    return tick_t'({$urandom, $urandom});
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void check_field(string name, tick_t want, tick_t got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Builds the next random frame. Most frames continue the stream contiguously; some open a
  // gap, step backwards, mark end of stream or carry arbitrary times. Realign asks for the
  // stream to be put back onto the predicted expected time once the frame has been taken.
  task automatic make_frame(output frame_t f, output bit realign);
    int unsigned pick;
    tick_t       step;
    tick_t       dur;
    pick    = $urandom_range(0, 99);
    realign = 1'b0;
    f.eos   = 1'b0;
    if (pick < 8) begin
      f.start = rand_ticks();
      f.stop  = rand_ticks();
      f.eos   = (pick < 4);
      realign = !f.eos;
      return;
    end
    if (pick < 11) begin
      src_cursor = exp_in_time + slip_acc;
    end else if (pick < 18) begin
      case ($urandom_range(0, 3))
        0: step = tick_t'($urandom_range(6290, 6310));
        1: step = tick_t'($urandom_range(6311, 300000));
        2: step = tick_t'($urandom_range(5399990, 5400010));
        default: begin
          step    = tick_t'($urandom_range(5400011, 30000000));
          realign = 1'b1;
        end
      endcase
      src_cursor = src_cursor + step;
    end else if (pick < 21) begin
      src_cursor = src_cursor - tick_t'($urandom_range(1, 3000));
    end else if (pick < 24) begin
      src_cursor = src_cursor - tick_t'($urandom_range(3001, 40000));
    end
    case ($urandom_range(0, 7))
      5: dur = tick_t'(2880);
      6: dur = tick_t'($urandom_range(1, 6000));
      7: dur = tick_t'($urandom_range(0, 100));
      default: dur = tick_t'(1920);
    endcase
    f.start    = src_cursor;
    f.stop     = src_cursor + dur;
    src_cursor = f.stop;
  endtask

  // Offers one frame and holds it until the block takes it, then records what it should give.
  task automatic send_frame(frame_t f, bit typed, sync_res_t want);
    sync_res_t predicted;
    in_if.valid         <= 1'b1;
    in_if.frame_start   <= f.start;
    in_if.frame_stop    <= f.stop;
    in_if.end_of_stream <= f.eos;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = retime_frame(f);
    due_results.push_back(typed ? want : predicted);
  endtask

  // Stops offering frames and waits until every result has been taken and the block is quiet.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == CfgGapMode) mode_q = value[0];
    else ticks_q = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that has not finished by now has hung somewhere.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_audio_timestamp_sync_top NOT OK");
    $finish;
  end

  // Result side: ready is withdrawn for random stretches while stalling is enabled.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (sink_stall_on) stall_left = idle_len();
      end
    end
  end

  // Every result transfer is compared, field by field, with the oldest prediction.
  always @(posedge clk_i) begin
    sync_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no frame outstanding");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("action", tick_t'(want.action), tick_t'(out_if.action));
        check_field("out_start", want.out_start, out_if.out_start);
        check_field("out_stop", want.out_stop, out_if.out_stop);
        check_field("silence_count", tick_t'(want.silence_count), tick_t'(out_if.silence_count));
        check_field("silence_start", want.silence_start, out_if.silence_start);
        check_field("slip_added", tick_t'(want.slip_added), tick_t'(out_if.slip_added));
      end
    end
  end

  initial begin
    frame_t      f;
    sync_res_t   want;
    bit          realign;
    int unsigned pause;
    int unsigned pick;

    // Reset values of the predictor match those of the block.
    mode_q        = 1'b0;
    ticks_q       = SilenceTicksReset;
    exp_in_time   = '0;
    next_out_time = '0;
    slip_acc      = '0;
    in_drop_run   = 1'b0;
    mismatches    = 0;
    src_cursor    = '0;
    src_pause_on  = 1'b1;
    sink_stall_on = 1'b1;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= '0;
    cfg_data_i          <= '0;
    in_if.valid         <= 1'b0;
    in_if.frame_start   <= '0;
    in_if.frame_stop    <= '0;
    in_if.end_of_stream <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows go back to back, with the result side stalling at random; the registers
    // are only touched once the block has gone quiet.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_FRAME) begin
        f    = '{start: dir_rows[i].start, stop: dir_rows[i].stop, eos: dir_rows[i].eos};
        want = '{action: dir_rows[i].want_action, out_start: dir_rows[i].want_start,
                 out_stop: dir_rows[i].want_stop, default: '0};
        send_frame(f, dir_rows[i].typed, want);
      end else begin
        wait_idle();
        write_reg(dir_rows[i].kind == ROW_SET_MODE ? CfgGapMode : CfgSilenceTicks,
                  dir_rows[i].value);
      end
    end

    // Random phases. Each one starts from an idle block with fresh settings, the first at the
    // extremes, and picks whether either side of the handshake idles at all.
    for (int phase_no = 0; phase_no < NumPhases; phase_no++) begin
      wait_idle();
      pick = $urandom_range(0, 5);
      write_reg(CfgGapMode, (phase_no < 2) ? CfgDataW'(phase_no) : CfgDataW'($urandom_range(0, 1)));
      case ((phase_no == 0) ? 1 : pick)
        0: write_reg(CfgSilenceTicks, 16'd1);
        1: write_reg(CfgSilenceTicks, 16'd65535);
        2: write_reg(CfgSilenceTicks, 16'd2880);
        3: write_reg(CfgSilenceTicks, 16'd0);
        default: write_reg(CfgSilenceTicks, CfgDataW'($urandom_range(1, 65535)));
      endcase
      src_pause_on  = (phase_no == 0) || ($urandom_range(0, 3) != 0);
      sink_stall_on = (phase_no == 0) || ($urandom_range(0, 3) != 0);
      src_cursor    = exp_in_time + slip_acc;

      for (int n = 0; n < PhaseItems; n++) begin
        make_frame(f, realign);
        send_frame(f, 1'b0, '0);
        if (realign) src_cursor = exp_in_time + slip_acc;
        pause = src_pause_on ? idle_len() : 0;
        if (n == PhaseItems / 2 || $urandom_range(0, 199) == 0) begin
          // Hold back the next frame until the result side has caught up completely.
          in_if.valid <= 1'b0;
          do @(posedge clk_i); while (due_results.size() != 0);
        end else if (pause != 0) begin
          in_if.valid <= 1'b0;
          repeat (pause) @(posedge clk_i);
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_audio_timestamp_sync_top OK");
    end else begin
      $display("tb_audio_timestamp_sync_top NOT OK");
    end
    $finish;
  end

endmodule
